[design/srcuv_pkg.sv]
// ----------------------------------------------------------------------------
// srcuv_pkg
// Shared constants for the sprite rectangle clip block.
// ----------------------------------------------------------------------------
`default_nettype none

package srcuv_pkg;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LEFT   = 2'd0,
        CFG_CLIP_TOP    = 2'd1,
        CFG_CLIP_WIDTH  = 2'd2,
        CFG_CLIP_HEIGHT = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

[design/srcuv_clip.sv]
// ----------------------------------------------------------------------------
// srcuv_clip
// First stage for one axis: interval intersection, clipped length and the
// offsets of both clipped edges from the rectangle origin.
// ----------------------------------------------------------------------------
`default_nettype none

module srcuv_clip #(
    parameter int COORD_WIDTH = 16,
    parameter int UV_WIDTH    = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_adv,
    input  wire logic signed [COORD_WIDTH-1:0] i_p,
    input  wire logic [COORD_WIDTH-2:0]        i_sz,
    input  wire logic signed [COORD_WIDTH-1:0] i_c0,
    input  wire logic [COORD_WIDTH-2:0]        i_csz,
    input  wire logic [UV_WIDTH-1:0]           i_t,
    input  wire logic [UV_WIDTH-1:0]           i_span,
    output logic [COORD_WIDTH-2:0]             o_a,
    output logic [COORD_WIDTH-2:0]             o_b,
    output logic [COORD_WIDTH-2:0]             o_sz,
    output logic signed [COORD_WIDTH-1:0]      o_lo,
    output logic [COORD_WIDTH-2:0]             o_len,
    output logic                               o_ok,
    output logic signed [COORD_WIDTH-1:0]      o_p,
    output logic [UV_WIDTH-1:0]                o_t,
    output logic [UV_WIDTH-1:0]                o_span
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = COORD_WIDTH - 1;

    logic signed [CW:0]   p_ext;
    logic signed [CW:0]   c0_ext;
    logic signed [CW:0]   p1;
    logic signed [CW:0]   c1;
    logic signed [CW:0]   lo;
    logic signed [CW:0]   hi;
    logic signed [CW+1:0] len;
    logic signed [CW+1:0] a_full;
    logic signed [CW+1:0] b_full;
    logic                 ok;

    logic [AW-1:0]        r_a, r_b, r_sz, r_len;
    logic signed [CW-1:0] r_lo, r_p;
    logic                 r_ok;
    logic [UV_WIDTH-1:0]  r_t, r_span;

    always_comb begin
        p_ext  = {i_p[CW-1], i_p};
        c0_ext = {i_c0[CW-1], i_c0};
        p1     = p_ext + $signed({2'b00, i_sz});
        c1     = c0_ext + $signed({2'b00, i_csz});
        lo     = (p_ext > c0_ext) ? p_ext : c0_ext;
        hi     = (p1 < c1) ? p1 : c1;
        len    = {hi[CW], hi} - {lo[CW], lo};
        a_full = {lo[CW], lo} - {p_ext[CW], p_ext};
        b_full = {hi[CW], hi} - {p_ext[CW], p_ext};
        ok     = !len[CW+1] && (len != '0) && (i_sz != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a    <= a_full[AW-1:0];
            r_b    <= b_full[AW-1:0];
            r_sz   <= i_sz;
            r_lo   <= lo[CW-1:0];
            r_len  <= len[AW-1:0];
            r_ok   <= ok;
            r_p    <= i_p;
            r_t    <= i_t;
            r_span <= i_span;
        end
    end

    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_sz   = r_sz;
    assign o_lo   = r_lo;
    assign o_len  = r_len;
    assign o_ok   = r_ok;
    assign o_p    = r_p;
    assign o_t    = r_t;
    assign o_span = r_span;

endmodule

`default_nettype wire

[design/srcuv_div_pipe.sv]
// ----------------------------------------------------------------------------
// srcuv_div_pipe
// floor(num * span / den): one multiply stage, then one restoring division
// step per quotient bit. Quotient fits UV_WIDTH bits since num <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module srcuv_div_pipe #(
    parameter int COORD_WIDTH = 16,
    parameter int UV_WIDTH    = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_adv,
    input  wire logic [COORD_WIDTH-2:0] i_num,
    input  wire logic [UV_WIDTH-1:0]    i_span,
    input  wire logic [COORD_WIDTH-2:0] i_den,
    output logic [UV_WIDTH-1:0]         o_quo
);

    localparam int AW = COORD_WIDTH - 1;
    localparam int UW = UV_WIDTH;
    localparam int PW = AW + UW;

    // upper AW bits: partial remainder, lower UW bits: dividend then quotient
    logic [PW-1:0] r_work [0:UW];
    logic [AW-1:0] r_den  [0:UW];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_work[0] <= PW'(i_num) * PW'(i_span);
            r_den[0]  <= i_den;
        end
    end

    for (genvar k = 1; k <= UW; k++) begin : g_step
        logic [AW:0] trial;
        logic [AW:0] diff;
        logic        ge;

        always_comb begin
            trial = r_work[k-1][PW-1:UW-1];
            ge    = trial >= {1'b0, r_den[k-1]};
            diff  = ge ? (trial - {1'b0, r_den[k-1]}) : trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_work[k] <= {diff[AW-1:0], r_work[k-1][UW-2:0], ge};
                r_den[k]  <= r_den[k-1];
            end
        end
    end

    assign o_quo = r_work[UW][UW-1:0];

endmodule

`default_nettype wire

[design/sprite_rect_clip_uv.sv]
// Throughput: one item per cycle while the output is not stalled; the divider is fully pipelined, one stage
// per quotient bit, four lanes (start and end on each axis).
// A stall on the output freezes the whole pipeline in place.
// Reset (synchronous, active low) clears all valid bits and sets the clip
// rectangle to origin 0, size 32767.
// ----------------------------------------------------------------------------
// sprite_rect_clip_uv
// Clips a textured rectangle against the clip rectangle and scales the
// texture origin and extent by the share cut from each side.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_rect_clip_uv #(
    parameter int COORD_WIDTH = 16,
    parameter int UV_WIDTH    = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [srcuv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [COORD_WIDTH-1:0]           i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic signed [COORD_WIDTH-1:0]    i_pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]    i_pos_y,
    input  wire logic [COORD_WIDTH-2:0]           i_size_w,
    input  wire logic [COORD_WIDTH-2:0]           i_size_h,
    input  wire logic [UV_WIDTH-1:0]              i_tex_u,
    input  wire logic [UV_WIDTH-1:0]              i_tex_v,
    input  wire logic [UV_WIDTH-1:0]              i_tex_span_u,
    input  wire logic [UV_WIDTH-1:0]              i_tex_span_v,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic signed [COORD_WIDTH-1:0]         o_out_x,
    output logic signed [COORD_WIDTH-1:0]         o_out_y,
    output logic [COORD_WIDTH-2:0]                o_out_w,
    output logic [COORD_WIDTH-2:0]                o_out_h,
    output logic [UV_WIDTH-1:0]                   o_out_u,
    output logic [UV_WIDTH-1:0]                   o_out_v,
    output logic [UV_WIDTH-1:0]                   o_out_span_u,
    output logic [UV_WIDTH-1:0]                   o_out_span_v,
    output logic                                  o_visible
);

    import srcuv_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int AW    = COORD_WIDTH - 1;
    localparam int UW    = UV_WIDTH;
    localparam int DEPTH = UV_WIDTH + 1;

    logic adv;

    // configuration
    logic signed [CW-1:0] r_clip_left, r_clip_top;
    logic [AW-1:0]        r_clip_width, r_clip_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_left   <= '0;
            r_clip_top    <= '0;
            r_clip_width  <= '1;
            r_clip_height <= '1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CLIP_LEFT:   r_clip_left   <= i_cfg_data;
                CFG_CLIP_TOP:    r_clip_top    <= i_cfg_data;
                CFG_CLIP_WIDTH:  r_clip_width  <= i_cfg_data[AW-1:0];
                CFG_CLIP_HEIGHT: r_clip_height <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: clip both axes
    logic [AW-1:0]        x_a, x_b, x_sz, x_len, y_a, y_b, y_sz, y_len;
    logic signed [CW-1:0] x_lo, x_p, y_lo, y_p;
    logic                 x_ok, y_ok;
    logic [UW-1:0]        x_t, x_span, y_t, y_span;

    srcuv_clip #(.COORD_WIDTH(COORD_WIDTH), .UV_WIDTH(UV_WIDTH)) u_clip_x (
        .i_clk (i_clk), .i_adv (adv),
        .i_p (i_pos_x), .i_sz (i_size_w), .i_c0 (r_clip_left), .i_csz (r_clip_width),
        .i_t (i_tex_u), .i_span (i_tex_span_u),
        .o_a (x_a), .o_b (x_b), .o_sz (x_sz), .o_lo (x_lo), .o_len (x_len),
        .o_ok (x_ok), .o_p (x_p), .o_t (x_t), .o_span (x_span)
    );

    srcuv_clip #(.COORD_WIDTH(COORD_WIDTH), .UV_WIDTH(UV_WIDTH)) u_clip_y (
        .i_clk (i_clk), .i_adv (adv),
        .i_p (i_pos_y), .i_sz (i_size_h), .i_c0 (r_clip_top), .i_csz (r_clip_height),
        .i_t (i_tex_v), .i_span (i_tex_span_v),
        .o_a (y_a), .o_b (y_b), .o_sz (y_sz), .o_lo (y_lo), .o_len (y_len),
        .o_ok (y_ok), .o_p (y_p), .o_t (y_t), .o_span (y_span)
    );

    // scaled texture offsets: start and end of each axis
    logic [UW-1:0] qs_x, qe_x, qs_y, qe_y;

    srcuv_div_pipe #(.COORD_WIDTH(COORD_WIDTH), .UV_WIDTH(UV_WIDTH)) u_div_sx (
        .i_clk (i_clk), .i_adv (adv), .i_num (x_a), .i_span (x_span), .i_den (x_sz),
        .o_quo (qs_x)
    );
    srcuv_div_pipe #(.COORD_WIDTH(COORD_WIDTH), .UV_WIDTH(UV_WIDTH)) u_div_ex (
        .i_clk (i_clk), .i_adv (adv), .i_num (x_b), .i_span (x_span), .i_den (x_sz),
        .o_quo (qe_x)
    );
    srcuv_div_pipe #(.COORD_WIDTH(COORD_WIDTH), .UV_WIDTH(UV_WIDTH)) u_div_sy (
        .i_clk (i_clk), .i_adv (adv), .i_num (y_a), .i_span (y_span), .i_den (y_sz),
        .o_quo (qs_y)
    );
    srcuv_div_pipe #(.COORD_WIDTH(COORD_WIDTH), .UV_WIDTH(UV_WIDTH)) u_div_ey (
        .i_clk (i_clk), .i_adv (adv), .i_num (y_b), .i_span (y_span), .i_den (y_sz),
        .o_quo (qe_y)
    );

    // side data delay line, aligned with the divider outputs
    logic                 r_v1;
    logic                 r_vsh    [0:DEPTH-1];
    logic                 r_ok_sh  [0:DEPTH-1];
    logic signed [CW-1:0] r_lox_sh [0:DEPTH-1];
    logic signed [CW-1:0] r_loy_sh [0:DEPTH-1];
    logic signed [CW-1:0] r_px_sh  [0:DEPTH-1];
    logic signed [CW-1:0] r_py_sh  [0:DEPTH-1];
    logic [AW-1:0]        r_lw_sh  [0:DEPTH-1];
    logic [AW-1:0]        r_lh_sh  [0:DEPTH-1];
    logic [UW-1:0]        r_tu_sh  [0:DEPTH-1];
    logic [UW-1:0]        r_tv_sh  [0:DEPTH-1];
    logic [UW-1:0]        r_su_sh  [0:DEPTH-1];
    logic [UW-1:0]        r_sv_sh  [0:DEPTH-1];
    logic                 r_out_valid;

    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < DEPTH; k++) begin
                r_vsh[k] <= 1'b0;
            end
        end else if (adv) begin
            r_v1        <= i_valid;
            r_vsh[0]    <= r_v1;
            for (int k = 1; k < DEPTH; k++) begin
                r_vsh[k] <= r_vsh[k-1];
            end
            r_out_valid <= r_vsh[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ok_sh[0]  <= x_ok && y_ok;
            r_lox_sh[0] <= x_lo;
            r_loy_sh[0] <= y_lo;
            r_px_sh[0]  <= x_p;
            r_py_sh[0]  <= y_p;
            r_lw_sh[0]  <= x_len;
            r_lh_sh[0]  <= y_len;
            r_tu_sh[0]  <= x_t;
            r_tv_sh[0]  <= y_t;
            r_su_sh[0]  <= x_span;
            r_sv_sh[0]  <= y_span;
            for (int k = 1; k < DEPTH; k++) begin
                r_ok_sh[k]  <= r_ok_sh[k-1];
                r_lox_sh[k] <= r_lox_sh[k-1];
                r_loy_sh[k] <= r_loy_sh[k-1];
                r_px_sh[k]  <= r_px_sh[k-1];
                r_py_sh[k]  <= r_py_sh[k-1];
                r_lw_sh[k]  <= r_lw_sh[k-1];
                r_lh_sh[k]  <= r_lh_sh[k-1];
                r_tu_sh[k]  <= r_tu_sh[k-1];
                r_tv_sh[k]  <= r_tv_sh[k-1];
                r_su_sh[k]  <= r_su_sh[k-1];
                r_sv_sh[k]  <= r_sv_sh[k-1];
            end
        end
    end

    // final stage: origin add with saturation, extent, hidden-item fallback
    logic [UW:0]   sum_u, sum_v;
    logic [UW-1:0] n_u, n_v, n_su, n_sv;
    logic signed [CW-1:0] n_x, n_y;
    logic [AW-1:0] n_w, n_h;
    logic          n_vis;

    logic signed [CW-1:0] r_x, r_y;
    logic [AW-1:0]        r_w, r_h;
    logic [UW-1:0]        r_u, r_v, r_su, r_sv;
    logic                 r_vis;

    always_comb begin
        sum_u = {1'b0, r_tu_sh[DEPTH-1]} + {1'b0, qs_x};
        sum_v = {1'b0, r_tv_sh[DEPTH-1]} + {1'b0, qs_y};
        n_vis = r_ok_sh[DEPTH-1];
        if (n_vis) begin
            n_x  = r_lox_sh[DEPTH-1];
            n_y  = r_loy_sh[DEPTH-1];
            n_w  = r_lw_sh[DEPTH-1];
            n_h  = r_lh_sh[DEPTH-1];
            n_u  = sum_u[UW] ? '1 : sum_u[UW-1:0];
            n_v  = sum_v[UW] ? '1 : sum_v[UW-1:0];
            n_su = qe_x - qs_x;
            n_sv = qe_y - qs_y;
        end else begin
            n_x  = r_px_sh[DEPTH-1];
            n_y  = r_py_sh[DEPTH-1];
            n_w  = '0;
            n_h  = '0;
            n_u  = r_tu_sh[DEPTH-1];
            n_v  = r_tv_sh[DEPTH-1];
            n_su = r_su_sh[DEPTH-1];
            n_sv = r_sv_sh[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_w   <= n_w;
            r_h   <= n_h;
            r_u   <= n_u;
            r_v   <= n_v;
            r_su  <= n_su;
            r_sv  <= n_sv;
            r_vis <= n_vis;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_x      = r_x;
    assign o_out_y      = r_y;
    assign o_out_w      = r_w;
    assign o_out_h      = r_h;
    assign o_out_u      = r_u;
    assign o_out_v      = r_v;
    assign o_out_span_u = r_su;
    assign o_out_span_v = r_sv;
    assign o_visible    = r_vis;

    a_vis_has_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_visible |-> (o_out_w != '0) && (o_out_h != '0))
        else $error("visible item with empty area");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> (o_out_w == '0) && (o_out_h == '0))
        else $error("hidden item with nonzero size");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v1)
        else $error("accepted item did not enter the pipeline");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vsh[DEPTH-1]) && $stable(r_v1))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
